@@ rtl/pcst_pkg.sv @@
// Package for the peak-count segment tree.
// Holds field widths, datapath operation codes and the controller status struct.
// No dependencies.
`default_nettype none

package pcst_pkg;

   localparam int TYPE_W = 1;
   localparam int POS_W = 10;
   localparam int VAL_W = 32;
   localparam int SIZE_W = 11;
   localparam int CNT_W = 11;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   localparam logic [TYPE_W-1:0] REQ_UPDATE = 1'b0;
   localparam logic [TYPE_W-1:0] REQ_QUERY = 1'b1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLR,
      OP_WRV,
      OP_SETI_ZERO,
      OP_SETI_POS,
      OP_SETI_DEC,
      OP_SETI_INC,
      OP_RDL,
      OP_RDC,
      OP_RDR,
      OP_WLEAF,
      OP_RDSIB,
      OP_WPAR,
      OP_SETK,
      OP_RDK0,
      OP_RDK1,
      OP_WK,
      OP_QINIT,
      OP_QLO,
      OP_QHI,
      OP_QSH,
      OP_RESP
   } op_type;

   typedef enum logic [2:0] {
      TAG_NONE,
      TAG_VL,
      TAG_VC,
      TAG_VR,
      TAG_CARRY,
      TAG_ACC
   } tag_type;

   typedef struct packed {
      logic bad;
      logic is_query;
      logic has_left;
      logic has_right;
      logic idx_last;
      logic walk_top;
      logic k_one;
      logic q_done;
      logic slot_free;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/pcst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcst_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/pcst_ctrl.sv @@
// Controller for the peak-count segment tree: sequences clear, rebuild, update and query.
// Depends on pcst_pkg.
`default_nettype none

module pcst_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   csr_write_enable,
   input  wire pcst_pkg::status_type   status,
   output pcst_pkg::op_type            op
);

   typedef enum logic [4:0] {
      S_CLR_INIT,
      S_CLR,
      S_REB_INIT,
      S_REB_RDL,
      S_REB_RDC,
      S_REB_RDR,
      S_REB_WAIT,
      S_REB_LEAF,
      S_REB_KINIT,
      S_REB_RD0,
      S_REB_RD1,
      S_REB_WK,
      S_IDLE,
      S_DECODE,
      S_UPD_WR,
      S_UPD_SET,
      S_RDL,
      S_RDC,
      S_RDR,
      S_WAIT,
      S_LEAF,
      S_SIB,
      S_PAR,
      S_QINIT,
      S_QCHK,
      S_QLO,
      S_QHI,
      S_QSH,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      PASS_CENTER,
      PASS_LEFT,
      PASS_RIGHT
   } pass_type;

   state_type state_ff, state_in;
   pass_type  pass_ff, pass_in;

   assign req_stall = (state_ff != S_IDLE) || csr_write_enable;

   always_comb begin
      state_in = state_ff;
      pass_in = pass_ff;
      op = pcst_pkg::OP_NONE;
      case (state_ff)
         S_CLR_INIT: begin
            op = pcst_pkg::OP_SETI_ZERO;
            state_in = S_CLR;
         end
         S_CLR: begin
            op = pcst_pkg::OP_CLR;
            if (status.idx_last) begin
               state_in = S_REB_INIT;
            end
         end
         S_REB_INIT: begin
            op = pcst_pkg::OP_SETI_ZERO;
            state_in = S_REB_RDL;
         end
         S_REB_RDL: begin
            op = pcst_pkg::OP_RDL;
            state_in = S_REB_RDC;
         end
         S_REB_RDC: begin
            op = pcst_pkg::OP_RDC;
            state_in = S_REB_RDR;
         end
         S_REB_RDR: begin
            op = pcst_pkg::OP_RDR;
            state_in = S_REB_WAIT;
         end
         S_REB_WAIT: begin
            state_in = S_REB_LEAF;
         end
         S_REB_LEAF: begin
            op = pcst_pkg::OP_WLEAF;
            state_in = status.idx_last ? S_REB_KINIT : S_REB_RDL;
         end
         S_REB_KINIT: begin
            op = pcst_pkg::OP_SETK;
            state_in = S_REB_RD0;
         end
         S_REB_RD0: begin
            op = pcst_pkg::OP_RDK0;
            state_in = S_REB_RD1;
         end
         S_REB_RD1: begin
            op = pcst_pkg::OP_RDK1;
            state_in = S_REB_WK;
         end
         S_REB_WK: begin
            op = pcst_pkg::OP_WK;
            state_in = status.k_one ? S_IDLE : S_REB_RD0;
         end
         S_IDLE: begin
            if (req_valid && !csr_write_enable) begin
               op = pcst_pkg::OP_ACCEPT;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.bad) begin
               state_in = S_RESP;
            end else if (status.is_query) begin
               state_in = S_QINIT;
            end else begin
               state_in = S_UPD_WR;
            end
         end
         S_UPD_WR: begin
            op = pcst_pkg::OP_WRV;
            pass_in = PASS_CENTER;
            state_in = S_UPD_SET;
         end
         S_UPD_SET: begin
            case (pass_ff)
               PASS_LEFT: op = pcst_pkg::OP_SETI_DEC;
               PASS_RIGHT: op = pcst_pkg::OP_SETI_INC;
               default: op = pcst_pkg::OP_SETI_POS;
            endcase
            state_in = S_RDL;
         end
         S_RDL: begin
            op = pcst_pkg::OP_RDL;
            state_in = S_RDC;
         end
         S_RDC: begin
            op = pcst_pkg::OP_RDC;
            state_in = S_RDR;
         end
         S_RDR: begin
            op = pcst_pkg::OP_RDR;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_LEAF;
         end
         S_LEAF: begin
            op = pcst_pkg::OP_WLEAF;
            state_in = S_SIB;
         end
         S_SIB: begin
            op = pcst_pkg::OP_RDSIB;
            state_in = S_PAR;
         end
         S_PAR: begin
            op = pcst_pkg::OP_WPAR;
            if (!status.walk_top) begin
               state_in = S_SIB;
            end else begin
               case (pass_ff)
                  PASS_CENTER: begin
                     if (status.has_left) begin
                        pass_in = PASS_LEFT;
                        state_in = S_UPD_SET;
                     end else if (status.has_right) begin
                        pass_in = PASS_RIGHT;
                        state_in = S_UPD_SET;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  PASS_LEFT: begin
                     if (status.has_right) begin
                        pass_in = PASS_RIGHT;
                        state_in = S_UPD_SET;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_QINIT: begin
            op = pcst_pkg::OP_QINIT;
            state_in = S_QCHK;
         end
         S_QCHK: begin
            state_in = status.q_done ? S_RESP : S_QLO;
         end
         S_QLO: begin
            op = pcst_pkg::OP_QLO;
            state_in = S_QHI;
         end
         S_QHI: begin
            op = pcst_pkg::OP_QHI;
            state_in = S_QSH;
         end
         S_QSH: begin
            op = pcst_pkg::OP_QSH;
            state_in = S_QCHK;
         end
         S_RESP: begin
            if (status.slot_free) begin
               op = pcst_pkg::OP_RESP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLR_INIT;
      endcase
      if (csr_write_enable && (state_ff != S_CLR_INIT) && (state_ff != S_CLR)) begin
         state_in = S_REB_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_INIT;
         pass_ff <= PASS_CENTER;
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in;
      end
   end

`ifndef SYNTH
   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && !req_stall) |=> (state_ff == S_DECODE))
      else $error("accepted item did not reach decode");

   a_resp_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !status.slot_free && !csr_write_enable) |=> (state_ff == S_RESP))
      else $error("result issued while output slot was full");
`endif

endmodule

`default_nettype wire

@@ rtl/pcst_dp.sv @@
// Datapath for the peak-count segment tree: value and count memories, walk registers.
// Depends on pcst_pkg and pcst_ram.
`default_nettype none

module pcst_dp #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int TREE_NODES = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pcst_pkg::op_type              op,
   output pcst_pkg::status_type               status,
   input  wire logic [pcst_pkg::TYPE_W-1:0]   req_type,
   input  wire logic [pcst_pkg::POS_W-1:0]    req_position,
   input  wire logic [pcst_pkg::POS_W-1:0]    req_right_end,
   input  wire logic signed [pcst_pkg::VAL_W-1:0] req_new_value,
   input  wire logic                          csr_write_enable,
   input  wire logic [pcst_pkg::SIZE_W-1:0]   csr_write_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [pcst_pkg::CNT_W-1:0]         rsp_peak_count,
   output logic                               rsp_bad_request
);

   localparam int IW = $clog2(MAX_ELEMENTS);
   localparam int SW = $clog2(MAX_ELEMENTS + 1);
   localparam int NW = $clog2(TREE_NODES);
   localparam int TW = SW;
   localparam int CW = (SW > pcst_pkg::SIZE_W) ? SW : pcst_pkg::SIZE_W;

   logic [pcst_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [pcst_pkg::TYPE_W-1:0] type_ff, type_in;
   logic [pcst_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [pcst_pkg::POS_W-1:0]  rend_ff, rend_in;
   logic [pcst_pkg::VAL_W-1:0]  val_ff, val_in;
   logic                        bad_ff, bad_in;
   logic [SW-1:0]               idx_ff, idx_in;
   logic [NW:0]                 node_ff, node_in;
   logic [NW:0]                 hi_ff, hi_in;
   logic [TW-1:0]               carry_ff, carry_in;
   logic [TW-1:0]               acc_ff, acc_in;
   logic [pcst_pkg::VAL_W-1:0]  vl_ff, vl_in;
   logic [pcst_pkg::VAL_W-1:0]  vc_ff, vc_in;
   logic [pcst_pkg::VAL_W-1:0]  vr_ff, vr_in;
   pcst_pkg::tag_type           tag_ff, tag_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pcst_pkg::CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                        rsp_bad_ff, rsp_bad_in;

   logic                        v_we;
   logic [IW-1:0]               v_waddr;
   logic [pcst_pkg::VAL_W-1:0]  v_wdata;
   logic [IW-1:0]               v_raddr;
   logic [pcst_pkg::VAL_W-1:0]  v_rdata;
   logic                        t_we;
   logic [NW-1:0]               t_waddr;
   logic [TW-1:0]               t_wdata;
   logic [NW-1:0]               t_raddr;
   logic [TW-1:0]               t_rdata;

   logic [SW-1:0]               eff;
   logic [CW-1:0]               eff_c;
   logic                        flag;
   logic                        gt_l;
   logic                        gt_r;
   logic [NW:0]                 leaf;
   logic [TW-1:0]               sum;
   logic [NW:0]                 hi_dec;

   pcst_ram #(.DATA_W(pcst_pkg::VAL_W), .DEPTH(MAX_ELEMENTS)) u_value_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_addr (v_raddr),
      .rd_data (v_rdata)
   );

   pcst_ram #(.DATA_W(TW), .DEPTH(TREE_NODES)) u_tree_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   assign eff = (CW'(size_ff) > CW'(MAX_ELEMENTS)) ? SW'(MAX_ELEMENTS) : SW'(size_ff);
   assign eff_c = CW'(eff);
   assign gt_l = $signed(vc_ff) > $signed(vl_ff);
   assign gt_r = $signed(vc_ff) > $signed(vr_ff);
   assign flag = (idx_ff < eff) &&
                 ((eff == SW'(1)) ||
                  (((idx_ff == '0) || gt_l) && ((idx_ff == eff - SW'(1)) || gt_r)));
   assign leaf = (NW+1)'(MAX_ELEMENTS) + (NW+1)'(idx_ff);
   assign sum = carry_ff + t_rdata;
   assign hi_dec = hi_ff - (NW+1)'(1);

   assign status.bad = bad_ff;
   assign status.is_query = (type_ff == pcst_pkg::REQ_QUERY);
   assign status.has_left = (pos_ff != '0);
   assign status.has_right = (CW'(pos_ff) + CW'(1)) < eff_c;
   assign status.idx_last = (idx_ff == SW'(MAX_ELEMENTS - 1));
   assign status.walk_top = (node_ff[NW:1] == NW'(1));
   assign status.k_one = (node_ff == (NW+1)'(1));
   assign status.q_done = (node_ff >= hi_ff);
   assign status.slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      size_in = size_ff;
      type_in = type_ff;
      pos_in = pos_ff;
      rend_in = rend_ff;
      val_in = val_ff;
      bad_in = bad_ff;
      idx_in = idx_ff;
      node_in = node_ff;
      hi_in = hi_ff;
      carry_in = carry_ff;
      acc_in = acc_ff;
      vl_in = vl_ff;
      vc_in = vc_ff;
      vr_in = vr_ff;
      tag_in = pcst_pkg::TAG_NONE;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_bad_in = rsp_bad_ff;
      v_we = 1'b0;
      v_waddr = IW'(idx_ff);
      v_wdata = '0;
      v_raddr = IW'(idx_ff);
      t_we = 1'b0;
      t_waddr = NW'(node_ff);
      t_wdata = sum;
      t_raddr = NW'(node_ff);

      case (tag_ff)
         pcst_pkg::TAG_VL: vl_in = v_rdata;
         pcst_pkg::TAG_VC: vc_in = v_rdata;
         pcst_pkg::TAG_VR: vr_in = v_rdata;
         pcst_pkg::TAG_CARRY: carry_in = t_rdata;
         pcst_pkg::TAG_ACC: acc_in = acc_ff + t_rdata;
         default: ;
      endcase

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_write_enable) begin
         size_in = csr_write_data;
      end

      case (op)
         pcst_pkg::OP_ACCEPT: begin
            type_in = req_type;
            pos_in = req_position;
            rend_in = req_right_end;
            val_in = req_new_value;
            acc_in = '0;
            if (req_type == pcst_pkg::REQ_QUERY) begin
               bad_in = (CW'(req_position) >= eff_c) || (CW'(req_right_end) >= eff_c) ||
                        (req_position > req_right_end);
            end else begin
               bad_in = CW'(req_position) >= eff_c;
            end
         end
         pcst_pkg::OP_CLR: begin
            v_we = 1'b1;
            idx_in = idx_ff + SW'(1);
         end
         pcst_pkg::OP_WRV: begin
            v_we = 1'b1;
            v_waddr = IW'(pos_ff);
            v_wdata = val_ff;
         end
         pcst_pkg::OP_SETI_ZERO: idx_in = '0;
         pcst_pkg::OP_SETI_POS: idx_in = SW'(pos_ff);
         pcst_pkg::OP_SETI_DEC: idx_in = SW'(pos_ff) - SW'(1);
         pcst_pkg::OP_SETI_INC: idx_in = SW'(pos_ff) + SW'(1);
         pcst_pkg::OP_RDL: begin
            v_raddr = IW'(idx_ff - SW'(1));
            tag_in = pcst_pkg::TAG_VL;
         end
         pcst_pkg::OP_RDC: begin
            v_raddr = IW'(idx_ff);
            tag_in = pcst_pkg::TAG_VC;
         end
         pcst_pkg::OP_RDR: begin
            v_raddr = IW'(idx_ff + SW'(1));
            tag_in = pcst_pkg::TAG_VR;
         end
         pcst_pkg::OP_WLEAF: begin
            t_we = 1'b1;
            t_waddr = NW'(leaf);
            t_wdata = TW'(flag);
            node_in = leaf;
            carry_in = TW'(flag);
            idx_in = idx_ff + SW'(1);
         end
         pcst_pkg::OP_RDSIB: t_raddr = NW'(node_ff ^ (NW+1)'(1));
         pcst_pkg::OP_WPAR: begin
            t_we = 1'b1;
            t_waddr = NW'(node_ff >> 1);
            carry_in = sum;
            node_in = node_ff >> 1;
         end
         pcst_pkg::OP_SETK: node_in = (NW+1)'(MAX_ELEMENTS - 1);
         pcst_pkg::OP_RDK0: begin
            t_raddr = NW'({node_ff, 1'b0});
            tag_in = pcst_pkg::TAG_CARRY;
         end
         pcst_pkg::OP_RDK1: t_raddr = NW'({node_ff, 1'b1});
         pcst_pkg::OP_WK: begin
            t_we = 1'b1;
            node_in = node_ff - (NW+1)'(1);
         end
         pcst_pkg::OP_QINIT: begin
            node_in = (NW+1)'(MAX_ELEMENTS) + (NW+1)'(pos_ff);
            hi_in = (NW+1)'(MAX_ELEMENTS) + (NW+1)'(rend_ff) + (NW+1)'(1);
         end
         pcst_pkg::OP_QLO: begin
            if (node_ff[0]) begin
               t_raddr = NW'(node_ff);
               tag_in = pcst_pkg::TAG_ACC;
               node_in = node_ff + (NW+1)'(1);
            end
         end
         pcst_pkg::OP_QHI: begin
            if (hi_ff[0]) begin
               t_raddr = NW'(hi_dec);
               tag_in = pcst_pkg::TAG_ACC;
               hi_in = hi_dec;
            end
         end
         pcst_pkg::OP_QSH: begin
            node_in = node_ff >> 1;
            hi_in = hi_ff >> 1;
         end
         pcst_pkg::OP_RESP: begin
            rsp_valid_in = 1'b1;
            rsp_count_in = pcst_pkg::CNT_W'(acc_ff);
            rsp_bad_in = bad_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= pcst_pkg::SIZE_RESET;
         tag_ff <= pcst_pkg::TAG_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff <= size_in;
         tag_ff <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff <= type_in;
      pos_ff <= pos_in;
      rend_ff <= rend_in;
      val_ff <= val_in;
      bad_ff <= bad_in;
      idx_ff <= idx_in;
      node_ff <= node_in;
      hi_ff <= hi_in;
      carry_ff <= carry_in;
      acc_ff <= acc_in;
      vl_ff <= vl_in;
      vc_ff <= vc_in;
      vr_ff <= vr_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff <= rsp_bad_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_peak_count = rsp_count_ff;
   assign rsp_bad_request = rsp_bad_ff;

`ifndef SYNTH
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_count_ff == '0))
      else $error("rejected item carries a nonzero count");

   a_query_order: assert property (@(posedge clock) disable iff (reset)
      (op == pcst_pkg::OP_QLO) |-> (node_ff < hi_ff))
      else $error("query bounds crossed");

   a_walk_depth: assert property (@(posedge clock) disable iff (reset)
      (op == pcst_pkg::OP_WPAR) |-> (node_ff >= (NW+1)'(2)))
      else $error("tree walk went past the root");
`endif

endmodule

`default_nettype wire

@@ rtl/peak_count_segment_tree.sv @@
// Peak-count segment tree: counts strict local peaks over a range of signed values.
// Update: writes the value, then rewrites the leaf at the position and at each neighbour, walking each up to the root.
// Query: sums the counts of the covering tree nodes from the leaves upward; one item at a time.
// Reset clears the value memory, then rebuilds the tree; a size write starts the same
// rebuild. Input stalls meanwhile.
// Depends on pcst_pkg, pcst_ctrl, pcst_dp and pcst_ram.
`default_nettype none

module peak_count_segment_tree #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int TREE_NODES = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [pcst_pkg::TYPE_W-1:0]       req_type,
   input  wire logic [pcst_pkg::POS_W-1:0]        req_position,
   input  wire logic [pcst_pkg::POS_W-1:0]        req_right_end,
   input  wire logic signed [pcst_pkg::VAL_W-1:0] req_new_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [pcst_pkg::CNT_W-1:0]             rsp_peak_count,
   output logic                                   rsp_bad_request,
   input  wire logic                              csr_write_enable,
   input  wire logic [pcst_pkg::SIZE_W-1:0]       csr_write_data
);

   pcst_pkg::op_type     op;
   pcst_pkg::status_type status;

   pcst_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .csr_write_enable (csr_write_enable),
      .status           (status),
      .op               (op)
   );

   pcst_dp #(.MAX_ELEMENTS(MAX_ELEMENTS), .TREE_NODES(TREE_NODES)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .status           (status),
      .req_type         (req_type),
      .req_position     (req_position),
      .req_right_end    (req_right_end),
      .req_new_value    (req_new_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_peak_count   (rsp_peak_count),
      .rsp_bad_request  (rsp_bad_request)
   );

endmodule

`default_nettype wire
